### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sbcr_pkg.sv
// ----------------------------------------------------------------------------
// sbcr_pkg
// types and constants of the spectrum bar column renderer
// ----------------------------------------------------------------------------
package sbcr_pkg;

  // sizes
  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLUMNS = 1024;
  localparam int COLOR_BITS  = 24;

  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int ROWS_CFG_W = 7;
  localparam int COL_W      = $clog2(MAX_COLUMNS);
  localparam int SAMPLE_W   = 17;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = SAMPLE_W + ROW_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // item modes
  typedef enum logic [1:0] {
    MODE_LOAD_TOP = 2'd0,
    MODE_LOAD_BAR = 2'd1,
    MODE_SAMPLE   = 2'd2,
    MODE_NONE     = 2'd3
  } mode_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS     = 2'd0,
    CFG_GRADIENT = 2'd1,
    CFG_OUTLINE  = 2'd2,
    CFG_LINE_CLR = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]          mode;
    logic                first_column;
    logic [SAMPLE_W-1:0] sample;
    logic [5:0]          table_index;
    logic [23:0]         table_color;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  column;
    logic [5:0]  row;
    logic [23:0] color;
    logic        last_row;
  } out_item_t;

endpackage

### rtl/core/spectrum_bar_column_renderer.sv
// ----------------------------------------------------------------------------
// spectrum_bar_column_renderer
// turns each spectrum sample into one column of pixels, top row first
// ----------------------------------------------------------------------------
// A table load item gives no pixel and leaves the block ready for a new
// item. A sample item goes through its accept, a multiply by the column
// height minus one, a saturate and line span step and then one row per
// cycle while the output pipeline advances, with the height held to 2..64
// rows; an output stall holds the row sequencer. The row sequencer reads
// both color tables once per row through their single read port. The block
// takes no new item until the last row read is issued; the final pixels
// drain through a two-stage output pipeline that follows the output ready.
module spectrum_bar_column_renderer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  sbcr_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output sbcr_pkg::out_item_t             out_item_o,
  input  logic                            cfg_we_i,
  input  logic [sbcr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sbcr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sbcr_pkg::*;

  `include "assert_macros.svh"

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_LEVEL = 2'd2;
  localparam logic [1:0] ST_RUN   = 2'd3;

  // configuration registers
  logic [ROWS_CFG_W-1:0] rows_cfg_q;
  logic                  gradient_q;
  logic                  outline_q;
  logic [COLOR_BITS-1:0] line_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q   <= ROWS_CFG_W'(MAX_ROWS);
      gradient_q   <= 1'b0;
      outline_q    <= 1'b0;
      line_color_q <= {COLOR_BITS{1'b1}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ROWS:     rows_cfg_q   <= cfg_data_i[ROWS_CFG_W-1:0];
        CFG_GRADIENT: gradient_q   <= cfg_data_i[0];
        CFG_OUTLINE:  outline_q    <= cfg_data_i[0];
        CFG_LINE_CLR: line_color_q <= cfg_data_i[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [1:0]          state_q, state_d;
  logic                first_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [ROW_W-1:0]    rows_m1_q;
  logic [PROD_W-1:0]   prod_q;
  logic [ROW_W-1:0]    level_q, lo_q, hi_q, row_q;
  logic [ROW_W-1:0]    prev_level_q;
  logic [COL_W-1:0]    col_cnt_q, col_q;

  logic in_accept, advance, issue, last_issue;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // output pipeline moves when the output register is free or taken
  logic out_valid_q;
  assign advance    = !out_valid_q || out_ready_i;
  assign issue      = (state_q == ST_RUN) && advance;
  assign last_issue = issue && (row_q == rows_m1_q);

  // clamped height minus one
  logic [ROW_W-1:0] rows_m1_d;
  always_comb begin
    priority if (rows_cfg_q < ROWS_CFG_W'(2)) begin
      rows_m1_d = ROW_W'(1);
    end else if (rows_cfg_q > ROWS_CFG_W'(MAX_ROWS)) begin
      rows_m1_d = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_m1_d = ROW_W'(rows_cfg_q - ROWS_CFG_W'(1));
    end
  end

  // saturated level and line span
  logic [SAMPLE_W-FRAC_W+ROW_W-1:0] level_raw;
  logic [ROW_W-1:0]                 level_d, prev_d;
  assign level_raw = prod_q[PROD_W-1:FRAC_W];
  assign level_d   = (level_raw > {{(SAMPLE_W-FRAC_W){1'b0}}, rows_m1_q}) ? rows_m1_q
                                                                           : level_raw[ROW_W-1:0];
  assign prev_d    = first_q ? level_d : prev_level_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_accept && (mode_e'(in_item_i.mode) == MODE_SAMPLE)) state_d = ST_MUL;
      ST_MUL:   state_d = ST_LEVEL;
      ST_LEVEL: state_d = ST_RUN;
      ST_RUN:   if (last_issue) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      prev_level_q <= '0;
      col_cnt_q    <= '0;
      row_q        <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_LEVEL) begin
        prev_level_q <= level_d;
        row_q        <= '0;
        if (first_q) begin
          col_cnt_q <= COL_W'(1);
        end else if (col_cnt_q == COL_W'(MAX_COLUMNS - 1)) begin
          col_cnt_q <= '0;
        end else begin
          col_cnt_q <= col_cnt_q + COL_W'(1);
        end
      end else if (issue) begin
        row_q <= row_q + ROW_W'(1);
      end
    end
  end

  // item and per-column registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      first_q   <= in_item_i.first_column;
      sample_q  <= in_item_i.sample;
      rows_m1_q <= rows_m1_d;
    end
    if (state_q == ST_MUL) begin
      prod_q <= PROD_W'(sample_q) * PROD_W'(rows_m1_q);
    end
    if (state_q == ST_LEVEL) begin
      level_q <= level_d;
      lo_q    <= (prev_d < level_d) ? prev_d : level_d;
      hi_q    <= (prev_d < level_d) ? level_d : prev_d;
      col_q   <= first_q ? '0 : col_cnt_q;
    end
  end

  // color tables
  logic [COLOR_BITS-1:0] top_mem [MAX_ROWS];
  logic [COLOR_BITS-1:0] bar_mem [MAX_ROWS];
  logic [COLOR_BITS-1:0] top_rd_q, bar_rd_q;
  logic [ROW_W-1:0]      bar_addr;
  assign bar_addr = gradient_q ? level_q : row_q;

  always_ff @(posedge clk_i) begin
    if (in_accept && (mode_e'(in_item_i.mode) == MODE_LOAD_TOP)) begin
      top_mem[in_item_i.table_index] <= in_item_i.table_color[COLOR_BITS-1:0];
    end
    if (issue) begin
      top_rd_q <= top_mem[row_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && (mode_e'(in_item_i.mode) == MODE_LOAD_BAR)) begin
      bar_mem[in_item_i.table_index] <= in_item_i.table_color[COLOR_BITS-1:0];
    end
    if (issue) begin
      bar_rd_q <= bar_mem[bar_addr];
    end
  end

  // read stage: row tags that travel with the table data
  logic             rd_valid_q, rd_top_q, rd_line_q, rd_last_q;
  logic [ROW_W-1:0] rd_row_q;
  logic [COL_W-1:0] rd_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      rd_valid_q  <= issue;
      out_valid_q <= rd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_row_q  <= row_q;
      rd_col_q  <= col_q;
      rd_top_q  <= (row_q < level_q);
      rd_line_q <= outline_q && (row_q >= lo_q) && (row_q <= hi_q);
      rd_last_q <= (row_q == rows_m1_q);
    end
  end

  // pixel color select and output register
  out_item_t out_d, out_q;
  always_comb begin
    out_d          = '0;
    out_d.column   = rd_col_q;
    out_d.row      = rd_row_q;
    out_d.last_row = rd_last_q;
    priority if (rd_line_q) begin
      out_d.color = line_color_q;
    end else if (rd_top_q) begin
      out_d.color = top_rd_q;
    end else begin
      out_d.color = bar_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && rd_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // checks
  `ASSERT_ALWAYS(a_level_in_column, (state_q != ST_RUN) || (level_q <= rows_m1_q), "level beyond column")
  `ASSERT_ALWAYS(a_span_ordered, (state_q != ST_RUN) || (lo_q <= hi_q), "line span reversed")
  `ASSERT_NEXT(a_level_to_run, state_q == ST_LEVEL, (state_q == ST_RUN) && (row_q == '0), "row scan did not start")

endmodule

### tb/spectrum_bar_column_checker.sv
// ----------------------------------------------------------------------------
// spectrum_bar_column_checker
// watches the item, pixel and register ports of the column renderer, keeps
// its own copy of the color tables, registers and column state, and checks
// every pixel against the one it predicts
// ----------------------------------------------------------------------------
module spectrum_bar_column_checker
  import sbcr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_item_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_item_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    pixels_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the block state
  logic [23:0] top_tbl [MAX_ROWS];
  logic [23:0] bar_tbl [MAX_ROWS];
  logic [6:0]  rows_cfg;
  logic        gradient_on;
  logic        outline_on;
  logic [23:0] line_clr;
  logic [5:0]  prev_level;
  logic [9:0]  col_count;

  // pixels predicted but not yet seen, oldest first
  out_item_t   pixel_q [$];

  // one line per mismatch, quiet after the first few
  task automatic report_mismatch(input string msg);
    if (fail_count_o < 40) $display("[%0t] mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  // register write, masked to register width
  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
    case (cfg_idx_e'(idx))
      CFG_ROWS:     rows_cfg    = data[6:0];
      CFG_GRADIENT: gradient_on = data[0];
      CFG_OUTLINE:  outline_on  = data[0];
      CFG_LINE_CLR: line_clr    = data;
      default: ;
    endcase
  endtask

  // predict all pixels of one column and advance the column state
  task automatic render_column(input in_item_t it);
    int          rows_n;
    int          prod;
    int          lvl_n;
    int          start_n;
    int          lo_n;
    int          hi_n;
    logic [23:0] shade;
    out_item_t   px;
    rows_n = rows_cfg;
    if (rows_n < 2) rows_n = 2;
    if (rows_n > MAX_ROWS) rows_n = MAX_ROWS;
    prod  = int'(it.sample) * (rows_n - 1);
    lvl_n = prod >>> FRAC_W;
    if (lvl_n > rows_n - 1) lvl_n = rows_n - 1;
    // first column of a frame restarts the counter and its line covers only the level row
    if (it.first_column) begin
      col_count = '0;
      start_n   = lvl_n;
    end else begin
      start_n = prev_level;
    end
    lo_n = (start_n < lvl_n) ? start_n : lvl_n;
    hi_n = (start_n < lvl_n) ? lvl_n : start_n;
    for (int r = 0; r < rows_n; r++) begin
      if (r < lvl_n) shade = top_tbl[r];
      else if (gradient_on) shade = bar_tbl[lvl_n];
      else shade = bar_tbl[r];
      if (outline_on && r >= lo_n && r <= hi_n) shade = line_clr;
      px.column   = col_count;
      px.row      = 6'(r);
      px.color    = shade;
      px.last_row = (r == rows_n - 1);
      pixel_q.push_back(px);
    end
    prev_level = 6'(lvl_n);
    col_count  = (col_count == 10'(MAX_COLUMNS - 1)) ? '0 : col_count + 10'd1;
  endtask

  // one accepted input transaction
  task automatic accept_item(input in_item_t it);
    case (mode_e'(it.mode))
      MODE_LOAD_TOP: top_tbl[it.table_index] = it.table_color;
      MODE_LOAD_BAR: bar_tbl[it.table_index] = it.table_color;
      MODE_SAMPLE:   render_column(it);
      default: ;
    endcase
  endtask

  // one accepted output transaction against the oldest prediction
  task automatic check_pixel(input out_item_t got);
    out_item_t want;
    if (pixel_q.size() == 0) begin
      report_mismatch($sformatf("pixel col %0d row %0d arrived with no column pending",
                                got.column, got.row));
      return;
    end
    want = pixel_q.pop_front();
    pixels_checked_o++;
    if (got.column !== want.column)
      report_mismatch($sformatf("column %0d, expected %0d (row %0d)",
                                got.column, want.column, want.row));
    if (got.row !== want.row)
      report_mismatch($sformatf("row %0d, expected %0d (column %0d)",
                                got.row, want.row, want.column));
    if (got.color !== want.color)
      report_mismatch($sformatf("color %06h, expected %06h (column %0d row %0d)",
                                got.color, want.color, want.column, want.row));
    if (got.last_row !== want.last_row)
      report_mismatch($sformatf("last_row %0b, expected %0b (column %0d row %0d)",
                                got.last_row, want.last_row, want.column, want.row));
  endtask

  // sample all three ports at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg         = 7'd64;
      gradient_on      = 1'b0;
      outline_on       = 1'b0;
      line_clr         = 24'hFFFFFF;
      prev_level       = '0;
      col_count        = '0;
      pixel_q.delete();
      pending_o        = 0;
      fail_count_o     = 0;
      pixels_checked_o = 0;
    end else begin
      if (cfg_we_i) apply_write(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) accept_item(in_item_i);
      if (out_valid_i && out_ready_i) check_pixel(out_item_i);
      pending_o = pixel_q.size();
    end
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives table loads, column samples and register settings into the spectrum
// bar column renderer with bursty input and a stalling pixel sink, and lets
// the checker compare every pixel; covers out-of-range heights, saturated
// samples, gradient and outline modes and frame restarts
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sbcr_pkg::*;

  localparam int RANDOM_ITEMS = 200;
  localparam int N_PHASES     = 10;
  localparam int END_WAIT     = 20000;

  // pixel sink stall patterns
  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_BURSTY
  } rx_pattern_e;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_item_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  int fail_count;
  int pending_pixels;
  int pixels_checked;

  // stimulus bookkeeping
  bit          top_loaded [MAX_ROWS];
  bit          bar_loaded [MAX_ROWS];
  int          rows_now      = 64;
  int          burst_left    = 0;
  bit          gaps_on       = 1'b1;
  rx_pattern_e rx_pattern    = RX_ALWAYS;
  int          columns_sent  = 0;
  int          loads_sent    = 0;
  int          ignored_sent  = 0;
  int          settings_used = 1;
  int          stall_left    = 0;
  bit          stall_level   = 1'b1;

  spectrum_bar_column_renderer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  spectrum_bar_column_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_item_i        (in_item_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_item_i       (out_item_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (fail_count),
    .pending_o        (pending_pixels),
    .pixels_checked_o (pixels_checked)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("spectrum_bar_column_renderer verification failed");
    $finish;
  end

  // pixel sink stalls
  always @(negedge clk_i) begin
    case (rx_pattern)
      RX_ALWAYS: out_ready_i <= 1'b1;
      RX_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left == 0) begin
          stall_level = !stall_level;
          stall_left  = stall_level ? $urandom_range(1, 16) : $urandom_range(1, 12);
        end else begin
          stall_left--;
        end
        out_ready_i <= stall_level;
      end
    endcase
  end

  function automatic in_item_t make_item(input mode_e m, input logic first,
                                         input logic [16:0] smp, input logic [5:0] idx,
                                         input logic [23:0] clr);
    in_item_t it;
    it.mode         = m;
    it.first_column = first;
    it.sample       = smp;
    it.table_index  = idx;
    it.table_color  = clr;
    return it;
  endfunction

  // mostly in range, with zero, full scale and above-one samples
  function automatic logic [16:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 17'd0;
      1:       return 17'd65536;
      2:       return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic in_item_t random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8)
      return make_item(MODE_NONE, 1'($urandom), 17'($urandom), 6'($urandom), 24'($urandom));
    if (pick < 35)
      return make_item(pick < 22 ? MODE_LOAD_TOP : MODE_LOAD_BAR, 1'($urandom),
                       17'($urandom), 6'($urandom), 24'($urandom));
    return make_item(MODE_SAMPLE, $urandom_range(0, 7) == 0, pick_sample(),
                     6'($urandom), 24'($urandom));
  endfunction

  // drive valid low and hold it there for the length given by n
  task automatic idle_input(input int n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // present one transaction and hold it until accepted
  task automatic push_item(input in_item_t it);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // bursts of random length, with random gaps between them when gaps_on is set
  task automatic drive_item(input in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) idle_input($urandom_range(1, 6));
    end
    burst_left--;
    push_item(it);
    case (mode_e'(it.mode))
      MODE_LOAD_TOP: begin
        top_loaded[it.table_index] = 1'b1;
        loads_sent++;
      end
      MODE_LOAD_BAR: begin
        bar_loaded[it.table_index] = 1'b1;
        loads_sent++;
      end
      MODE_SAMPLE: columns_sent++;
      default: ignored_sent++;
    endcase
  endtask

  // a column only reads table entries that were loaded
  task automatic issue(input in_item_t it);
    if (it.mode == MODE_SAMPLE) begin
      for (int i = 0; i < rows_now; i++) begin
        if (!top_loaded[i])
          drive_item(make_item(MODE_LOAD_TOP, 1'($urandom), 17'($urandom), 6'(i),
                               24'($urandom)));
        if (!bar_loaded[i])
          drive_item(make_item(MODE_LOAD_BAR, 1'($urandom), 17'($urandom), 6'(i),
                               24'($urandom)));
      end
    end
    drive_item(it);
  endtask

  // hold off input until every predicted pixel has come out
  task automatic wait_drained();
    idle_input(1);
    while (pending_pixels != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [23:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // all four registers, junk in the unused upper bits
  task automatic set_regs(input int rows, input bit grad, input bit outline,
                          input logic [23:0] line);
    logic [23:0] junk;
    junk = 24'($urandom);
    write_reg(CFG_ROWS, {junk[23:7], 7'(rows)});
    junk = 24'($urandom);
    write_reg(CFG_GRADIENT, {junk[23:1], grad});
    junk = 24'($urandom);
    write_reg(CFG_OUTLINE, {junk[23:1], outline});
    write_reg(CFG_LINE_CLR, line);
    rows_now = (rows < 2) ? 2 : ((rows > MAX_ROWS) ? MAX_ROWS : rows);
    settings_used++;
  endtask

  task automatic run_random(input int n);
    in_item_t it;
    int       done;
    done = 0;
    while (done < n) begin
      it = random_item();
      issue(it);
      if (it.mode != MODE_NONE) done++;
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
  endtask

  // stimulus and verdict
  initial begin
    int k;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings, table extremes, sample extremes, ignored mode
    issue(make_item(MODE_NONE, 1'b1, 17'h1FFFF, 6'h3F, 24'hFFFFFF));
    issue(make_item(MODE_LOAD_TOP, 1'b1, 17'h1FFFF, 6'd0, 24'h000000));
    issue(make_item(MODE_LOAD_TOP, 1'b0, 17'h00000, 6'd63, 24'hFFFFFF));
    issue(make_item(MODE_LOAD_BAR, 1'b1, 17'h1FFFF, 6'd0, 24'hFFFFFF));
    issue(make_item(MODE_LOAD_BAR, 1'b0, 17'h00000, 6'd63, 24'h000000));
    issue(make_item(MODE_SAMPLE, 1'b1, 17'd0, 6'd0, 24'd0));
    issue(make_item(MODE_SAMPLE, 1'b0, 17'd65536, 6'h3F, 24'hFFFFFF));
    issue(make_item(MODE_SAMPLE, 1'b0, 17'h1FFFF, 6'd0, 24'd0));
    issue(make_item(MODE_SAMPLE, 1'b0, 17'd65535, 6'd0, 24'd0));
    issue(make_item(MODE_SAMPLE, 1'b0, 17'd1, 6'd0, 24'd0));
    issue(make_item(MODE_SAMPLE, 1'b0, 17'd32768, 6'd0, 24'd0));
    issue(make_item(MODE_SAMPLE, 1'b1, 17'd40000, 6'd0, 24'd0));
    issue(make_item(MODE_NONE, 1'b0, 17'd0, 6'd0, 24'd0));
    wait_drained();

    // fixed extreme settings first, then random ones
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       set_regs(2, 1'b0, 1'b1, 24'h000000);
        1:       set_regs(0, 1'b1, 1'b1, 24'($urandom));
        2:       set_regs(127, 1'b1, 1'b0, 24'hFFFFFF);
        3:       set_regs(1, 1'b0, 1'b1, 24'($urandom));
        4:       set_regs(64, 1'b1, 1'b1, 24'h000000);
        5:       set_regs(65, 1'b0, 1'b1, 24'hFFFFFF);
        default: set_regs(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(2, 20),
                          1'($urandom), 1'($urandom), 24'($urandom));
      endcase
      rx_pattern = rx_pattern_e'($urandom_range(0, 2));
      gaps_on    = ($urandom_range(0, 2) != 0);
      // line spans up and down at the smallest height
      if (p == 0) begin
        issue(make_item(MODE_SAMPLE, 1'b1, 17'd0, 6'd0, 24'd0));
        issue(make_item(MODE_SAMPLE, 1'b0, 17'd65536, 6'd0, 24'd0));
        issue(make_item(MODE_SAMPLE, 1'b0, 17'd0, 6'd0, 24'd0));
      end
      run_random(RANDOM_ITEMS / N_PHASES);
      wait_drained();
    end

    // drain and settle
    idle_input(1);
    k = 0;
    while (k < END_WAIT && pending_pixels != 0) begin
      @(negedge clk_i);
      k++;
    end
    repeat (80) @(negedge clk_i);
    if (pending_pixels != 0) $display("%0d predicted pixels never came out", pending_pixels);
    $display("covered %0d columns, %0d table loads and %0d ignored items over %0d settings",
             columns_sent, loads_sent, ignored_sent, settings_used);
    $display("%0d pixels compared under bursty input and a stalling sink", pixels_checked);
    if (fail_count == 0 && pending_pixels == 0) begin
      $display("spectrum_bar_column_renderer verification clean");
    end else begin
      $display("spectrum_bar_column_renderer verification failed");
    end
    $finish;
  end

endmodule

### spectrum_bar_column_renderer.f
+incdir+rtl/core
rtl/core/sbcr_pkg.sv
rtl/core/spectrum_bar_column_renderer.sv
tb/spectrum_bar_column_checker.sv
tb/testbench.sv
